FILE: sv/widr_pkg.sv
// ----------------------------------------------------------------------------
// widr_pkg
// Shared types, constants and tables for the wheel/imu dead reckoning block.
// ----------------------------------------------------------------------------
package widr_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int AtanEntries = 24;
   localparam logic [31:0] CordicKQ30 = 32'd652032874;
   localparam logic [19:0] CircReset = 20'd100000;
   localparam int QueueDepthDefault = 2;

   typedef enum logic [1:0] {
      FUNC_ORIENT = 2'd0,
      FUNC_PERIOD = 2'd1,
      FUNC_TICK   = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   localparam logic CSR_CIRC = 1'b0;
   localparam logic CSR_REV  = 1'b1;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] rate_z_in;
      logic [31:0]        period_us;
      logic [31:0]        elapsed_us;
   } req_type;

   typedef struct packed {
      logic signed [63:0] pos_x;
      logic signed [63:0] pos_y;
      logic signed [31:0] speed_out;
      logic signed [15:0] rate_z_out;
      logic signed [15:0] orient_w;
      logic signed [15:0] orient_x;
      logic signed [15:0] orient_y;
      logic signed [15:0] orient_z;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      func_type    func;
      logic [15:0] qw;
      logic [15:0] qx;
      logic [15:0] qy;
      logic [15:0] qz;
      logic [15:0] rate;
      logic [31:0] value;
   } cmd_type;

   function automatic logic [31:0] atan_lut(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'd536870912;
         5'd1:  r = 32'd316933406;
         5'd2:  r = 32'd167458907;
         5'd3:  r = 32'd85004756;
         5'd4:  r = 32'd42667331;
         5'd5:  r = 32'd21354465;
         5'd6:  r = 32'd10679838;
         5'd7:  r = 32'd5340245;
         5'd8:  r = 32'd2670163;
         5'd9:  r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: sv/wheel_imu_dead_reckoning.sv
// ----------------------------------------------------------------------------
// wheel_imu_dead_reckoning
// Planar odometry from quaternion orientation and wheel period samples.
// ----------------------------------------------------------------------------
// An orientation item runs the yaw products, then one vectoring step per
// cycle; a period item runs a 36-bit restoring divider, one quotient bit
// per cycle; a tick that emits a result runs the rotation steps, then
// multiply, round, scale and accumulate. The back end runs one item at a
// time; a QUEUE_DEPTH-entry queue (two by default) lets the front keep
// accepting while it works. A result sits in an output register; while
// it is stalled the back end only waits if another result is ready. Only
// ticks with both samples seen and nonzero elapsed time produce a result
// item.
module wheel_imu_dead_reckoning #(
   parameter int CORDIC_STEPS = widr_pkg::CordicStepsDefault,
   parameter int QUEUE_DEPTH  = widr_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  widr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output widr_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [19:0]       csr_wdata
);
   logic [19:0]       circ_ff;
   logic              rev_ff;
   logic              cmd_valid, cmd_pop;
   widr_pkg::cmd_type cmd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         circ_ff <= widr_pkg::CircReset;
         rev_ff  <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == widr_pkg::CSR_CIRC) circ_ff <= csr_wdata;
         if (csr_index == widr_pkg::CSR_REV)  rev_ff  <= csr_wdata[0];
      end
   end

   widr_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .cmd_valid, .cmd_pop, .cmd_data
   );

   widr_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock, .reset, .circ(circ_ff), .reverse(rev_ff),
      .cmd_valid, .cmd_pop, .cmd_data, .rsp_valid, .rsp_stall, .rsp_data
   );

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");

   // a popped command implies a queued one
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("pop from empty queue");
endmodule

FILE: sv/widr_front.sv
// ----------------------------------------------------------------------------
// widr_front
// Accepts request items, drops unused codes and empty ticks early, and
// pushes commands into a short queue for the back end.
// ----------------------------------------------------------------------------
module widr_front #(
   parameter int QUEUE_DEPTH = widr_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  widr_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_pop,
   output widr_pkg::cmd_type cmd_data
);
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   widr_pkg::cmd_type    mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]        wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]          cnt_ff, cnt_in;
   widr_pkg::cmd_type    cmd;
   logic                 accept, keep, push, pop;

   assign req_stall = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // classify: unused code and zero-time ticks never reach the back end
   always_comb begin
      cmd.func  = widr_pkg::func_type'(req_data.func);
      cmd.qw    = req_data.quat_w;
      cmd.qx    = req_data.quat_x;
      cmd.qy    = req_data.quat_y;
      cmd.qz    = req_data.quat_z;
      cmd.rate  = req_data.rate_z_in;
      cmd.value = (cmd.func == widr_pkg::FUNC_TICK) ? req_data.elapsed_us
                                                     : req_data.period_us;
      keep = (cmd.func != widr_pkg::FUNC_NONE) &&
             !(cmd.func == widr_pkg::FUNC_TICK && req_data.elapsed_us == 32'd0);
   end

   assign push      = accept && keep;
   assign pop       = cmd_pop && (cnt_ff != '0);
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_data  = mem_ff[rd_ff];

   // pointer wrap
   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= cmd;
   end
endmodule

FILE: sv/widr_back.sv
// ----------------------------------------------------------------------------
// widr_back
// Executes commands: CORDIC vectoring for yaw, restoring divide for speed,
// CORDIC rotation and multiply-accumulate for the position update.
// ----------------------------------------------------------------------------
module widr_back #(
   parameter int CORDIC_STEPS = widr_pkg::CordicStepsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [19:0]       circ,
   input  logic              reverse,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  widr_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output widr_pkg::rsp_type rsp_data
);
   localparam int NS = (CORDIC_STEPS < widr_pkg::AtanEntries) ? CORDIC_STEPS
                                                              : widr_pkg::AtanEntries;

   typedef enum logic [3:0] {
      S_IDLE, S_YAW_MUL, S_YAW_SUM, S_VEC, S_YAW_END, S_DIV, S_DIV_END,
      S_ROT, S_MUL, S_RND, S_DT, S_ACC, S_OUT
   } state_type;

   state_type          state_ff;
   logic [4:0]         step_ff;
   logic [5:0]         dstep_ff;
   logic signed [63:0] ax_ff, ay_ff;     // cordic x/c and y/s
   logic signed [33:0] za_ff;
   logic [31:0]        ang_ff;
   logic signed [31:0] m_wz_ff, m_xy_ff, m_yy_ff, m_zz_ff;
   logic [51:0]        rem_ff;
   logic [35:0]        num_ff;
   logic [35:0]        quo_ff;
   logic [31:0]        div_ff;
   logic               flip_ff;
   logic signed [63:0] px_ff, py_ff, qx_ff, qy_ff;
   logic [63:0]        dx_ff, dy_ff;
   logic [31:0]        dt_ff;
   logic [15:0]        heading_ff;
   logic signed [31:0] speed_ff;
   logic [15:0]        ow_ff, ox_ff, oy_ff, oz_ff, rate_ff;
   logic               oseen_ff, sseen_ff;
   logic [63:0]        posx_ff, posy_ff;
   logic               rsp_valid_ff;
   widr_pkg::rsp_type  rsp_ff;

   logic signed [63:0] shx, shy;
   logic [31:0]        atn;
   logic [52:0]        trial;
   logic [31:0]        za_word;

   assign shx     = ax_ff >>> step_ff;
   assign shy     = ay_ff >>> step_ff;
   assign atn     = widr_pkg::atan_lut(step_ff);
   assign trial   = {rem_ff, num_ff[35]} - {21'd0, div_ff};
   assign za_word = {heading_ff, 16'd0};

   assign cmd_pop   = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         heading_ff   <= '0;
         speed_ff     <= '0;
         ow_ff <= '0; ox_ff <= '0; oy_ff <= '0; oz_ff <= '0; rate_ff <= '0;
         oseen_ff     <= 1'b0;
         sseen_ff     <= 1'b0;
         posx_ff      <= '0;
         posy_ff      <= '0;
      end else begin
         // result taken; the output state reloads it on its own
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  unique case (cmd_data.func)
                     widr_pkg::FUNC_ORIENT: begin
                        ow_ff <= cmd_data.qw; ox_ff <= cmd_data.qx;
                        oy_ff <= cmd_data.qy; oz_ff <= cmd_data.qz;
                        rate_ff  <= cmd_data.rate;
                        oseen_ff <= 1'b1;
                        state_ff <= S_YAW_MUL;
                     end
                     widr_pkg::FUNC_PERIOD: begin
                        if (cmd_data.value == 32'd0) begin
                           speed_ff <= '0;
                        end else begin
                           div_ff   <= cmd_data.value;
                           num_ff   <= {circ, 16'd0};
                           rem_ff   <= '0;
                           quo_ff   <= '0;
                           dstep_ff <= '0;
                           state_ff <= S_DIV;
                        end
                     end
                     widr_pkg::FUNC_TICK: begin
                        if (oseen_ff && sseen_ff) begin
                           dt_ff   <= cmd_data.value;
                           ax_ff   <= 64'(widr_pkg::CordicKQ30);
                           ay_ff   <= '0;
                           step_ff <= '0;
                           // fold into [-pi/2, pi/2]
                           if (!za_word[31] && za_word > 32'h4000_0000) begin
                              za_ff <= 34'($signed({2'b00, za_word})) - 34'sh0_8000_0000;
                              flip_ff <= 1'b1;
                           end else if (za_word[31] && za_word < 32'hC000_0000) begin
                              za_ff <= 34'($signed({2'b11, za_word})) + 34'sh0_8000_0000;
                              flip_ff <= 1'b1;
                           end else begin
                              za_ff   <= 34'($signed({za_word[31], za_word[31], za_word}));
                              flip_ff <= 1'b0;
                           end
                           state_ff <= S_ROT;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            // yaw products, one multiplier each
            S_YAW_MUL: begin
               m_wz_ff  <= $signed(ow_ff) * $signed(oz_ff);
               m_xy_ff  <= $signed(ox_ff) * $signed(oy_ff);
               m_yy_ff  <= $signed(oy_ff) * $signed(oy_ff);
               m_zz_ff  <= $signed(oz_ff) * $signed(oz_ff);
               state_ff <= S_YAW_SUM;
            end
            S_YAW_SUM: begin : yaw_sum
               logic signed [63:0] s, c;
               s = 64'sd2 * (64'(m_wz_ff) + 64'(m_xy_ff));
               c = 64'sd1073741824 - 64'sd2 * (64'(m_yy_ff) + 64'(m_zz_ff));
               step_ff <= '0;
               if (s == 0 && c == 0) begin
                  heading_ff <= '0;
                  state_ff   <= S_IDLE;
               end else if (c < 0) begin
                  ax_ff <= -c; ay_ff <= -s; ang_ff <= 32'h8000_0000;
                  state_ff <= S_VEC;
               end else begin
                  ax_ff <= c; ay_ff <= s; ang_ff <= '0;
                  state_ff <= S_VEC;
               end
            end
            // vectoring, one step a cycle
            S_VEC: begin
               if (ay_ff > 0) begin
                  ax_ff <= ax_ff + shy; ay_ff <= ay_ff - shx; ang_ff <= ang_ff + atn;
               end else begin
                  ax_ff <= ax_ff - shy; ay_ff <= ay_ff + shx; ang_ff <= ang_ff - atn;
               end
               if (step_ff == 5'(NS - 1)) state_ff <= S_YAW_END;
               step_ff <= step_ff + 1'b1;
            end
            // round the angle to the 16-bit heading
            S_YAW_END: begin : yaw_fin
               logic [31:0] r;
               r = ang_ff + 32'h8000;
               heading_ff <= r[31:16];
               state_ff   <= S_IDLE;
            end
            // restoring divide, one quotient bit a cycle
            S_DIV: begin
               num_ff <= {num_ff[34:0], 1'b0};
               if (!trial[52]) begin
                  rem_ff <= trial[51:0];
                  quo_ff <= {quo_ff[34:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[50:0], num_ff[35]};
                  quo_ff <= {quo_ff[34:0], 1'b0};
               end
               if (dstep_ff == 6'd35) state_ff <= S_DIV_END;
               dstep_ff <= dstep_ff + 1'b1;
            end
            // saturate and sign the speed
            S_DIV_END: begin : fin
               logic [31:0] mag;
               mag = (quo_ff > 36'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_ff[31:0];
               speed_ff <= reverse ? -$signed(mag) : $signed(mag);
               sseen_ff <= 1'b1;
               dstep_ff <= '0;
               state_ff <= S_IDLE;
            end
            // rotation, one step a cycle
            S_ROT: begin
               if (!za_ff[33]) begin
                  ax_ff <= ax_ff - shy; ay_ff <= ay_ff + shx;
                  za_ff <= za_ff - 34'($signed({2'b00, atn}));
               end else begin
                  ax_ff <= ax_ff + shy; ay_ff <= ay_ff - shx;
                  za_ff <= za_ff + 34'($signed({2'b00, atn}));
               end
               if (step_ff == 5'(NS - 1)) state_ff <= S_MUL;
               step_ff <= step_ff + 1'b1;
            end
            S_MUL: begin
               px_ff <= speed_ff * $signed(flip_ff ? -ax_ff[31:0] : ax_ff[31:0]);
               py_ff <= speed_ff * $signed(flip_ff ? -ay_ff[31:0] : ay_ff[31:0]);
               state_ff <= S_RND;
            end
            S_RND: begin
               qx_ff <= (px_ff + 64'sd536870912) >>> 30;
               qy_ff <= (py_ff + 64'sd536870912) >>> 30;
               state_ff <= S_DT;
            end
            // rounded step fits 33 bits signed, elapsed time 32 bits unsigned
            S_DT: begin : scale
               logic signed [65:0] tx, ty;
               tx = $signed(qx_ff[32:0]) * $signed({1'b0, dt_ff});
               ty = $signed(qy_ff[32:0]) * $signed({1'b0, dt_ff});
               dx_ff <= tx[63:0];
               dy_ff <= ty[63:0];
               state_ff <= S_ACC;
            end
            S_ACC: begin
               posx_ff  <= posx_ff + dx_ff;
               posy_ff  <= posy_ff + dy_ff;
               state_ff <= S_OUT;
            end
            // load the output register once the previous item is gone
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_ff.pos_x      <= posx_ff;
                  rsp_ff.pos_y      <= posy_ff;
                  rsp_ff.speed_out  <= speed_ff;
                  rsp_ff.rate_z_out <= rate_ff;
                  rsp_ff.orient_w   <= ow_ff;
                  rsp_ff.orient_x   <= ox_ff;
                  rsp_ff.orient_y   <= oy_ff;
                  rsp_ff.orient_z   <= oz_ff;
                  state_ff          <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
